FILE: sv/s5h_pkg.sv
// Shared types, codes and byte constants for the SOCKS5 connect handshake unit.
`timescale 1ns / 1ps

package s5h_pkg;

   // Request opcodes.
   localparam logic [1:0] OP_START = 2'd0;
   localparam logic [1:0] OP_HOST  = 2'd1;
   localparam logic [1:0] OP_RX    = 2'd2;

   // Status codes reported to the user.
   localparam logic [2:0] ST_CONNECTED     = 3'd0;
   localparam logic [2:0] ST_BAD_VERSION   = 3'd1;
   localparam logic [2:0] ST_AUTH_UNSUPP   = 3'd2;
   localparam logic [2:0] ST_HOST_INVALID  = 3'd3;
   localparam logic [2:0] ST_REPLY_BAD_VER = 3'd4;
   localparam logic [2:0] ST_CONNECT_FAIL  = 3'd5;
   localparam logic [2:0] ST_UNKNOWN_ATYP  = 3'd6;
   localparam logic [2:0] ST_OUT_OF_SEQ    = 3'd7;

   // Result kinds.
   localparam logic KIND_TX     = 1'b0;
   localparam logic KIND_STATUS = 1'b1;

   // Protocol bytes.
   localparam logic [7:0] SOCKS_VER      = 8'h05;
   localparam logic [7:0] NUM_METHODS    = 8'h01;
   localparam logic [7:0] METHOD_NO_AUTH = 8'h00;
   localparam logic [7:0] CMD_CONNECT    = 8'h01;
   localparam logic [7:0] RSV_BYTE       = 8'h00;
   localparam logic [7:0] REP_SUCCESS    = 8'h00;
   localparam logic [7:0] ATYP_IPV4      = 8'h01;
   localparam logic [7:0] ATYP_DOMAIN    = 8'h03;
   localparam logic [7:0] ATYP_IPV6      = 8'h04;

   // Bytes of bound address plus port to skip.
   localparam logic [8:0] SKIP_IPV4      = 9'd6;
   localparam logic [8:0] SKIP_IPV6      = 9'd18;
   localparam logic [8:0] SKIP_PORT      = 9'd2;

   // Work orders handed from the front end to the back end.
   typedef enum logic [2:0] {
      JOB_GREET     = 3'd0,
      JOB_REQUEST   = 3'd1,
      JOB_HOST      = 3'd2,
      JOB_HOST_PORT = 3'd3,
      JOB_STATUS    = 3'd4
   } job_type;

   typedef struct packed {
      job_type     job;
      logic [7:0]  data;
      logic [15:0] port;
      logic [2:0]  status;
   } desc_type;

   // Index of the final byte of each job.
   function automatic logic [2:0] job_last_idx(input job_type job);
      logic [2:0] idx;
      unique case (job)
         JOB_GREET:     idx = 3'd2;
         JOB_REQUEST:   idx = 3'd4;
         JOB_HOST_PORT: idx = 3'd2;
         default:       idx = 3'd0;
      endcase
      return idx;
   endfunction

endpackage

FILE: sv/s5h_front.sv
// Front end: accepts requests, runs the handshake sequence and issues jobs.
`timescale 1ns / 1ps

module s5h_front (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  logic [1:0]        req_opcode,
   input  logic [7:0]        req_host_length,
   input  logic [15:0]       req_dest_port,
   input  logic [7:0]        req_host_byte,
   input  logic [7:0]        req_rx_byte,
   input  logic              queue_full,
   output logic              push,
   output s5h_pkg::desc_type push_desc
);
   import s5h_pkg::*;

   typedef enum logic [9:0] {
      PH_BLOCKED = 10'b0000000001,
      PH_CHOICE0 = 10'b0000000010,
      PH_CHOICE1 = 10'b0000000100,
      PH_HOST    = 10'b0000001000,
      PH_REP0    = 10'b0000010000,
      PH_REP1    = 10'b0000100000,
      PH_REP2    = 10'b0001000000,
      PH_REP3    = 10'b0010000000,
      PH_DOMLEN  = 10'b0100000000,
      PH_SKIP    = 10'b1000000000
   } phase_type;

   phase_type   phase_ff, phase_in;
   logic [8:0]  count_ff, count_in;
   logic [7:0]  host_len_ff, host_len_in;
   logic [15:0] port_ff, port_in;
   logic [2:0]  saved_ff, saved_in;

   logic        accept;
   logic [8:0]  count_inc;
   logic [8:0]  count_dec;
   logic [2:0]  choice_err;

   assign req_stall = queue_full;
   assign accept    = req_valid && !req_stall;
   assign count_inc = count_ff + 9'd1;
   assign count_dec = (count_ff != 9'd0) ? count_ff - 9'd1 : count_ff;

   always_comb begin
      choice_err = saved_ff;
      if (saved_ff == ST_CONNECTED && req_rx_byte != METHOD_NO_AUTH) begin
         choice_err = ST_AUTH_UNSUPP;
      end
   end

   always_comb begin
      phase_in    = phase_ff;
      count_in    = count_ff;
      host_len_in = host_len_ff;
      port_in     = port_ff;
      saved_in    = saved_ff;
      push        = 1'b0;
      push_desc   = '{job: JOB_STATUS, data: 8'd0, port: port_ff, status: ST_OUT_OF_SEQ};
      if (accept) begin
         unique case (req_opcode)
            OP_START: begin
               host_len_in   = req_host_length;
               port_in       = req_dest_port;
               count_in      = 9'd0;
               saved_in      = ST_CONNECTED;
               push          = 1'b1;
               push_desc.job = JOB_GREET;
               phase_in      = PH_CHOICE0;
            end
            OP_HOST: begin
               push = 1'b1;
               if (phase_ff != PH_HOST) begin
                  phase_in = PH_BLOCKED;
               end else begin
                  push_desc.data = req_host_byte;
                  push_desc.job  = JOB_HOST;
                  count_in       = count_inc;
                  if (count_inc >= {1'b0, host_len_ff}) begin
                     push_desc.job = JOB_HOST_PORT;
                     saved_in      = ST_CONNECTED;
                     phase_in      = PH_REP0;
                  end
               end
            end
            OP_RX: begin
               unique case (phase_ff)
                  PH_CHOICE0: begin
                     saved_in = (req_rx_byte == SOCKS_VER) ? ST_CONNECTED : ST_BAD_VERSION;
                     phase_in = PH_CHOICE1;
                  end
                  PH_CHOICE1: begin
                     saved_in = choice_err;
                     push     = 1'b1;
                     if (choice_err != ST_CONNECTED) begin
                        push_desc.status = choice_err;
                        phase_in         = PH_BLOCKED;
                     end else if (host_len_ff == 8'd0) begin
                        push_desc.status = ST_HOST_INVALID;
                        phase_in         = PH_BLOCKED;
                     end else begin
                        push_desc.job  = JOB_REQUEST;
                        push_desc.data = host_len_ff;
                        count_in       = 9'd0;
                        phase_in       = PH_HOST;
                     end
                  end
                  PH_REP0: begin
                     saved_in = (req_rx_byte == SOCKS_VER) ? ST_CONNECTED : ST_REPLY_BAD_VER;
                     phase_in = PH_REP1;
                  end
                  PH_REP1: begin
                     if (saved_ff == ST_CONNECTED && req_rx_byte != REP_SUCCESS) begin
                        saved_in = ST_CONNECT_FAIL;
                     end
                     phase_in = PH_REP2;
                  end
                  PH_REP2: begin
                     phase_in = PH_REP3;
                  end
                  PH_REP3: begin
                     if (saved_ff != ST_CONNECTED) begin
                        push             = 1'b1;
                        push_desc.status = saved_ff;
                        phase_in         = PH_BLOCKED;
                     end else if (req_rx_byte == ATYP_IPV4) begin
                        count_in = SKIP_IPV4;
                        phase_in = PH_SKIP;
                     end else if (req_rx_byte == ATYP_DOMAIN) begin
                        phase_in = PH_DOMLEN;
                     end else if (req_rx_byte == ATYP_IPV6) begin
                        count_in = SKIP_IPV6;
                        phase_in = PH_SKIP;
                     end else begin
                        push             = 1'b1;
                        push_desc.status = ST_UNKNOWN_ATYP;
                        phase_in         = PH_BLOCKED;
                     end
                  end
                  PH_DOMLEN: begin
                     count_in = {1'b0, req_rx_byte} + SKIP_PORT;
                     phase_in = PH_SKIP;
                  end
                  PH_SKIP: begin
                     count_in = count_dec;
                     if (count_dec == 9'd0) begin
                        push             = 1'b1;
                        push_desc.status = ST_CONNECTED;
                        phase_in         = PH_BLOCKED;
                     end
                  end
                  default: begin
                     push     = 1'b1;
                     phase_in = PH_BLOCKED;
                  end
               endcase
            end
            default: begin
               push     = 1'b1;
               phase_in = PH_BLOCKED;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff    <= PH_BLOCKED;
         count_ff    <= 9'd0;
         host_len_ff <= 8'd0;
         port_ff     <= 16'd0;
         saved_ff    <= ST_CONNECTED;
      end else begin
         phase_ff    <= phase_in;
         count_ff    <= count_in;
         host_len_ff <= host_len_in;
         port_ff     <= port_in;
         saved_ff    <= saved_in;
      end
   end

endmodule

FILE: sv/s5h_fifo.sv
// Short job queue between the front end and the back end.
`timescale 1ns / 1ps

module s5h_fifo #(
   parameter int DEPTH = 4
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  s5h_pkg::desc_type push_desc,
   output logic              full,
   output logic              not_empty,
   input  logic              pop,
   output s5h_pkg::desc_type pop_desc
);
   import s5h_pkg::*;

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   desc_type         slot_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] fill_ff, fill_in;

   assign full      = (fill_ff == CNT_W'(DEPTH));
   assign not_empty = (fill_ff != '0);
   assign pop_desc  = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      fill_in   = fill_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (push && !pop) begin
         fill_in = fill_ff + CNT_W'(1);
      end else if (pop && !push) begin
         fill_in = fill_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_desc;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

endmodule

FILE: sv/s5h_back.sv
// Back end: expands each job into its results, one per cycle while rsp_stall is low.
`timescale 1ns / 1ps

module s5h_back (
   input  logic              clock,
   input  logic              reset,
   input  logic              job_ready,
   input  s5h_pkg::desc_type job_desc,
   output logic              job_pop,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output logic              rsp_kind,
   output logic [7:0]        rsp_tx_byte,
   output logic [2:0]        rsp_status,
   output logic              rsp_last
);
   import s5h_pkg::*;

   desc_type   cur_ff, cur_in;
   logic       busy_ff, busy_in;
   logic [2:0] idx_ff, idx_in;
   logic       fire;

   assign rsp_valid = busy_ff;
   assign fire      = busy_ff && !rsp_stall;
   assign rsp_last  = (idx_ff == job_last_idx(cur_ff.job));
   assign job_pop   = job_ready && (!busy_ff || (fire && rsp_last));

   always_comb begin
      rsp_kind    = KIND_TX;
      rsp_status  = ST_CONNECTED;
      rsp_tx_byte = 8'd0;
      unique case (cur_ff.job)
         JOB_GREET: begin
            unique case (idx_ff)
               3'd0:    rsp_tx_byte = SOCKS_VER;
               3'd1:    rsp_tx_byte = NUM_METHODS;
               default: rsp_tx_byte = METHOD_NO_AUTH;
            endcase
         end
         JOB_REQUEST: begin
            unique case (idx_ff)
               3'd0:    rsp_tx_byte = SOCKS_VER;
               3'd1:    rsp_tx_byte = CMD_CONNECT;
               3'd2:    rsp_tx_byte = RSV_BYTE;
               3'd3:    rsp_tx_byte = ATYP_DOMAIN;
               default: rsp_tx_byte = cur_ff.data;
            endcase
         end
         JOB_HOST: begin
            rsp_tx_byte = cur_ff.data;
         end
         JOB_HOST_PORT: begin
            unique case (idx_ff)
               3'd0:    rsp_tx_byte = cur_ff.data;
               3'd1:    rsp_tx_byte = cur_ff.port[15:8];
               default: rsp_tx_byte = cur_ff.port[7:0];
            endcase
         end
         default: begin
            rsp_kind   = KIND_STATUS;
            rsp_status = cur_ff.status;
         end
      endcase
   end

   always_comb begin
      cur_in  = cur_ff;
      busy_in = busy_ff;
      idx_in  = idx_ff;
      if (job_pop) begin
         cur_in  = job_desc;
         busy_in = 1'b1;
         idx_in  = 3'd0;
      end else if (fire) begin
         if (rsp_last) begin
            busy_in = 1'b0;
         end else begin
            idx_in = idx_ff + 3'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cur_ff  <= '0;
         busy_ff <= 1'b0;
         idx_ff  <= 3'd0;
      end else begin
         cur_ff  <= cur_in;
         busy_ff <= busy_in;
         idx_ff  <= idx_in;
      end
   end

endmodule

FILE: sv/socks5_connect_handshake_unit.sv
// Top level of the SOCKS5 client no-auth CONNECT handshake unit.
`timescale 1ns / 1ps

// Channel  | Direction | Handshake            | Payload
// req_     | in        | req_valid/req_stall  | opcode, host_length, dest_port, host_byte, rx_byte
// rsp_     | out       | rsp_valid/rsp_stall  | kind, tx_byte, status, last
//
// The front end classifies a request and updates the handshake state in the
// cycle it is accepted, so a new request can be taken every cycle while the
// job queue has room. Each request yields zero to five results and the back
// end sends one result per cycle while rsp_stall is low; the queue absorbs
// bursts, and a request that yields nothing takes no output time. With the
// back end idle, the first result is offered once its job has passed the
// queue and been loaded into the back end's registers. Reset is synchronous
// and leaves the unit blocked until a start request. req_stall is raised
// only when the job queue is full; rsp_stall holds the current result steady.

module socks5_connect_handshake_unit #(
   parameter int FIFO_DEPTH = 4
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [1:0]  req_opcode,
   input  logic [7:0]  req_host_length,
   input  logic [15:0] req_dest_port,
   input  logic [7:0]  req_host_byte,
   input  logic [7:0]  req_rx_byte,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic        rsp_kind,
   output logic [7:0]  rsp_tx_byte,
   output logic [2:0]  rsp_status,
   output logic        rsp_last
);
   import s5h_pkg::*;

   // Jobs from the front end into the queue.
   logic     push;
   desc_type push_desc;
   logic     queue_full;

   // Jobs out of the queue into the back end.
   logic     job_ready;
   logic     job_pop;
   desc_type job_desc;

   // The front end owns all protocol state; it never waits on the output side
   // except through the queue's full flag.
   s5h_front u_front (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_opcode      (req_opcode),
      .req_host_length (req_host_length),
      .req_dest_port   (req_dest_port),
      .req_host_byte   (req_host_byte),
      .req_rx_byte     (req_rx_byte),
      .queue_full      (queue_full),
      .push            (push),
      .push_desc       (push_desc)
   );

   s5h_fifo #(
      .DEPTH (FIFO_DEPTH)
   ) u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_desc (push_desc),
      .full      (queue_full),
      .not_empty (job_ready),
      .pop       (job_pop),
      .pop_desc  (job_desc)
   );

   // The back end holds the job being sent in registers, and pulls the next
   // job in the same cycle its last result is taken, so results stream out
   // without gaps.
   s5h_back u_back (
      .clock       (clock),
      .reset       (reset),
      .job_ready   (job_ready),
      .job_desc    (job_desc),
      .job_pop     (job_pop),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_kind    (rsp_kind),
      .rsp_tx_byte (rsp_tx_byte),
      .rsp_status  (rsp_status),
      .rsp_last    (rsp_last)
   );

endmodule

FILE: tb/sv/tb_socks5_connect_handshake_unit.sv
// Self-checking testbench for the SOCKS5 connect handshake unit: directed table plus random sessions.
`timescale 1ns / 1ps

// The testbench keeps its own model of the client handshake. Every request
// that the unit accepts is run through that model at the accepting edge, and
// the results it owes are queued. Every result that the unit hands over is
// compared field by field with the oldest owed result.
//
// The run has three parts. First, a short table of directed requests is
// walked with no idling. Rows whose outcome is plain from the protocol (the
// error codes and the blocked state after reset) carry their expected status
// in the table. All other rows are checked against the model. Next come four
// phases of random sessions, each with its own idle and stall rates. Most
// sessions are well formed with random content, and some are broken or are
// plain noise. The sender pauses between phases until every owed result has
// arrived. Last, the run lets stray results show up and then ends.

module tb_socks5_connect_handshake_unit;

   import s5h_pkg::*;

   // An opcode that the unit does not define. It must be answered as out of
   // sequence.
   localparam logic [1:0] OP_BAD = 2'd3;

   // How a table row is checked: by the model, or against a status typed in.
   localparam logic CHK_PRED  = 1'b0;
   localparam logic CHK_TYPED = 1'b1;

   localparam int NUM_DIRECTED  = 27;
   localparam int PHASE_ITEMS   = 40;
   localparam int SETTLE_CYCLES = 16;
   localparam int MAX_REPORTS   = 10;

   // One request as the sender sees it, plus how its results are checked.
   typedef struct packed {
      logic [1:0]  opcode;
      logic [7:0]  host_length;
      logic [15:0] dest_port;
      logic [7:0]  host_byte;
      logic [7:0]  rx_byte;
      logic        chk;
      logic [2:0]  chk_status;
   } req_type;

   // One result as it leaves the unit.
   typedef struct packed {
      logic       kind;
      logic [7:0] tx_byte;
      logic [2:0] status;
      logic       last;
   } rsp_type;

   // The phases of the handshake as the model tracks them.
   typedef enum logic [3:0] {
      HS_BLOCKED = 4'd0,
      HS_CHOICE0 = 4'd1,
      HS_CHOICE1 = 4'd2,
      HS_HOST    = 4'd3,
      HS_REP0    = 4'd4,
      HS_REP1    = 4'd5,
      HS_REP2    = 4'd6,
      HS_REP3    = 4'd7,
      HS_DOMLEN  = 4'd8,
      HS_SKIP    = 4'd9
   } hs_phase_type;

   // Every input of the unit has a known value from time zero on.
   logic    clock     = 1'b0;
   logic    reset     = 1'b1;
   logic    req_valid = 1'b0;
   logic    rsp_stall = 1'b0;
   req_type cur_req   = '0;

   logic       req_stall;
   logic       rsp_valid;
   logic       rsp_kind;
   logic [7:0] rsp_tx_byte;
   logic [2:0] rsp_status;
   logic       rsp_last;

   // Requests waiting to be offered, and results the unit still owes.
   req_type req_backlog [$];
   rsp_type owed_rsps [$];
   rsp_type step_rsps [$];

   // The model's copy of the handshake state.
   hs_phase_type m_phase;
   logic [8:0]   m_count;
   logic [7:0]   m_len;
   logic [15:0]  m_port;
   logic [7:0]   m_saved;

   int send_idle_pct  = 0;
   int recv_stall_pct = 0;
   int fail_count     = 0;
   logic    req_taken;
   rsp_type got_rsp;

   // The directed table. The fields that a row does not use hold extreme
   // values, so that the extremes of every field appear early in the run.
   req_type directed_tbl [NUM_DIRECTED] = '{
      // The unit comes out of reset blocked, so a host byte and an undefined
      // opcode are both out of sequence.
      '{OP_HOST,  8'hFF, 16'hFFFF, 8'hFF, 8'hFF, CHK_TYPED, ST_OUT_OF_SEQ},
      '{OP_BAD,   8'hFF, 16'hFFFF, 8'hFF, 8'hFF, CHK_TYPED, ST_OUT_OF_SEQ},
      // A host length of zero still sends the greeting. It is rejected once a
      // valid method choice has come back.
      '{OP_START, 8'h00, 16'h0000, 8'h00, 8'h00, CHK_PRED,  ST_CONNECTED},
      '{OP_RX,    8'h00, 16'h0000, 8'h00, 8'h05, CHK_PRED,  ST_CONNECTED},
      '{OP_RX,    8'h00, 16'h0000, 8'h00, 8'h00, CHK_TYPED, ST_HOST_INVALID},
      // A bad version and a bad method arrive together. The version wins.
      '{OP_START, 8'h01, 16'hFFFF, 8'hFF, 8'hFF, CHK_PRED,  ST_CONNECTED},
      '{OP_RX,    8'hFF, 16'hFFFF, 8'hFF, 8'h04, CHK_PRED,  ST_CONNECTED},
      '{OP_RX,    8'hFF, 16'hFFFF, 8'hFF, 8'hFF, CHK_TYPED, ST_BAD_VERSION},
      // A good version with a method that needs authentication.
      '{OP_START, 8'h01, 16'hA55A, 8'h00, 8'h00, CHK_PRED,  ST_CONNECTED},
      '{OP_RX,    8'h00, 16'h0000, 8'h00, 8'h05, CHK_PRED,  ST_CONNECTED},
      '{OP_RX,    8'h00, 16'h0000, 8'h00, 8'h01, CHK_TYPED, ST_AUTH_UNSUPP},
      // The longest host name. One byte goes out, and then a start drops the
      // handshake halfway.
      '{OP_START, 8'hFF, 16'h1234, 8'h00, 8'h00, CHK_PRED,  ST_CONNECTED},
      '{OP_RX,    8'h00, 16'h0000, 8'h00, 8'h05, CHK_PRED,  ST_CONNECTED},
      '{OP_RX,    8'h00, 16'h0000, 8'h00, 8'h00, CHK_PRED,  ST_CONNECTED},
      '{OP_HOST,  8'h00, 16'h0000, 8'h00, 8'h00, CHK_PRED,  ST_CONNECTED},
      '{OP_START, 8'h01, 16'hFFFF, 8'hFF, 8'hFF, CHK_PRED,  ST_CONNECTED},
      '{OP_RX,    8'h00, 16'h0000, 8'h00, 8'h05, CHK_PRED,  ST_CONNECTED},
      '{OP_RX,    8'h00, 16'h0000, 8'h00, 8'h00, CHK_PRED,  ST_CONNECTED},
      // A received byte while the unit waits for host bytes.
      '{OP_RX,    8'hFF, 16'hFFFF, 8'hFF, 8'h05, CHK_TYPED, ST_OUT_OF_SEQ},
      // Full request, then a reply with a bad version and a nonzero REP
      // byte. The version is reported once the whole header is in.
      '{OP_START, 8'h01, 16'hFFFF, 8'hFF, 8'hFF, CHK_PRED,  ST_CONNECTED},
      '{OP_RX,    8'h00, 16'h0000, 8'h00, 8'h05, CHK_PRED,  ST_CONNECTED},
      '{OP_RX,    8'h00, 16'h0000, 8'h00, 8'h00, CHK_PRED,  ST_CONNECTED},
      '{OP_HOST,  8'h00, 16'h0000, 8'hFF, 8'h00, CHK_PRED,  ST_CONNECTED},
      '{OP_RX,    8'h00, 16'h0000, 8'h00, 8'h00, CHK_PRED,  ST_CONNECTED},
      '{OP_RX,    8'h00, 16'h0000, 8'h00, 8'h01, CHK_PRED,  ST_CONNECTED},
      '{OP_RX,    8'h00, 16'h0000, 8'h00, 8'h00, CHK_PRED,  ST_CONNECTED},
      '{OP_RX,    8'h00, 16'h0000, 8'h00, 8'h01, CHK_TYPED, ST_REPLY_BAD_VER}
   };

   socks5_connect_handshake_unit dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_opcode      (cur_req.opcode),
      .req_host_length (cur_req.host_length),
      .req_dest_port   (cur_req.dest_port),
      .req_host_byte   (cur_req.host_byte),
      .req_rx_byte     (cur_req.rx_byte),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_kind        (rsp_kind),
      .rsp_tx_byte     (rsp_tx_byte),
      .rsp_status      (rsp_status),
      .rsp_last        (rsp_last)
   );

   always #4 clock = ~clock;

   // ---------------------------------------------------------------------
   // Handshake model
   // ---------------------------------------------------------------------

   task automatic emit_tx(input logic [7:0] b);
      step_rsps.insert(step_rsps.size(), '{KIND_TX, b, ST_CONNECTED, 1'b0});
   endtask

   // A status report always ends the handshake and leaves the unit blocked.
   task automatic emit_status(input logic [2:0] st);
      step_rsps.insert(step_rsps.size(), '{KIND_STATUS, 8'h00, st, 1'b0});
      m_phase = HS_BLOCKED;
   endtask

   task automatic socks_model_reset();
      m_phase = HS_BLOCKED;
      m_count = '0;
      m_len   = '0;
      m_port  = '0;
      m_saved = '0;
   endtask

   // Runs one request through the model. The results it causes are left in
   // step_rsps, with last set on the final one.
   task automatic predict_socks_step(input req_type r);
      rsp_type tail;
      step_rsps.delete();
      case (r.opcode)
         OP_START: begin
            m_len   = r.host_length;
            m_port  = r.dest_port;
            m_count = '0;
            m_saved = '0;
            emit_tx(SOCKS_VER);
            emit_tx(NUM_METHODS);
            emit_tx(METHOD_NO_AUTH);
            m_phase = HS_CHOICE0;
         end
         OP_HOST: begin
            if (m_phase != HS_HOST) begin
               emit_status(ST_OUT_OF_SEQ);
            end else begin
               emit_tx(r.host_byte);
               m_count = m_count + 9'd1;
               if (m_count >= {1'b0, m_len}) begin
                  emit_tx(m_port[15:8]);
                  emit_tx(m_port[7:0]);
                  m_saved = '0;
                  m_phase = HS_REP0;
               end
            end
         end
         OP_RX: begin
            case (m_phase)
               HS_CHOICE0: begin
                  m_saved = (r.rx_byte == SOCKS_VER) ? 8'd0 : {5'd0, ST_BAD_VERSION};
                  m_phase = HS_CHOICE1;
               end
               HS_CHOICE1: begin
                  if (m_saved == 8'd0 && r.rx_byte != METHOD_NO_AUTH)
                     m_saved = {5'd0, ST_AUTH_UNSUPP};
                  if (m_saved != 8'd0) begin
                     emit_status(m_saved[2:0]);
                  end else if (m_len == 8'd0) begin
                     emit_status(ST_HOST_INVALID);
                  end else begin
                     emit_tx(SOCKS_VER);
                     emit_tx(CMD_CONNECT);
                     emit_tx(RSV_BYTE);
                     emit_tx(ATYP_DOMAIN);
                     emit_tx(m_len);
                     m_count = '0;
                     m_phase = HS_HOST;
                  end
               end
               HS_REP0: begin
                  m_saved = (r.rx_byte == SOCKS_VER) ? 8'd0 : {5'd0, ST_REPLY_BAD_VER};
                  m_phase = HS_REP1;
               end
               HS_REP1: begin
                  if (m_saved == 8'd0 && r.rx_byte != REP_SUCCESS)
                     m_saved = {5'd0, ST_CONNECT_FAIL};
                  m_phase = HS_REP2;
               end
               HS_REP2: begin
                  m_phase = HS_REP3;
               end
               HS_REP3: begin
                  if (m_saved != 8'd0) begin
                     emit_status(m_saved[2:0]);
                  end else if (r.rx_byte == ATYP_IPV4) begin
                     m_count = SKIP_IPV4;
                     m_phase = HS_SKIP;
                  end else if (r.rx_byte == ATYP_DOMAIN) begin
                     m_phase = HS_DOMLEN;
                  end else if (r.rx_byte == ATYP_IPV6) begin
                     m_count = SKIP_IPV6;
                     m_phase = HS_SKIP;
                  end else begin
                     emit_status(ST_UNKNOWN_ATYP);
                  end
               end
               HS_DOMLEN: begin
                  m_count = {1'b0, r.rx_byte} + SKIP_PORT;
                  m_phase = HS_SKIP;
               end
               HS_SKIP: begin
                  if (m_count != 9'd0)
                     m_count = m_count - 9'd1;
                  if (m_count == 9'd0)
                     emit_status(ST_CONNECTED);
               end
               default: begin
                  emit_status(ST_OUT_OF_SEQ);
               end
            endcase
         end
         default: begin
            emit_status(ST_OUT_OF_SEQ);
         end
      endcase
      if (step_rsps.size() > 0) begin
         tail = step_rsps.pop_back();
         tail.last = 1'b1;
         step_rsps.insert(step_rsps.size(), tail);
      end
   endtask

   // ---------------------------------------------------------------------
   // Random sessions
   // ---------------------------------------------------------------------

   // Fields that the opcode does not use get random values, so every bit of
   // every field is exercised.
   function automatic req_type rand_req(input logic [1:0] op);
      req_type r;
      r.opcode      = op;
      r.host_length = 8'($urandom);
      r.dest_port   = 16'($urandom);
      r.host_byte   = 8'($urandom);
      r.rx_byte     = 8'($urandom);
      r.chk         = CHK_PRED;
      r.chk_status  = ST_CONNECTED;
      return r;
   endfunction

   task automatic queue_req(input req_type r);
      req_backlog.insert(req_backlog.size(), r);
   endtask

   task automatic queue_rx(input logic [7:0] b);
      req_type r;
      r = rand_req(OP_RX);
      r.rx_byte = b;
      queue_req(r);
   endtask

   task automatic queue_noise();
      queue_req(rand_req(2'($urandom_range(0, 3))));
   endtask

   // Mostly a well-formed session with random content. Now and then a byte
   // is corrupted or a session is cut short. A few sessions are pure noise.
   task automatic queue_session();
      int len;
      int pick;
      int skip;
      int k;
      logic bad;
      logic [7:0] b0;
      logic [7:0] b1;
      logic [7:0] atyp;
      req_type r;

      if ($urandom_range(0, 9) == 0) begin
         repeat ($urandom_range(1, 4)) queue_noise();
         return;
      end

      pick = $urandom_range(0, 9);
      if (pick == 0)
         len = 0;
      else if (pick == 1)
         len = $urandom_range(7, 20);
      else if (pick == 2)
         len = $urandom_range(0, 255);
      else
         len = $urandom_range(1, 6);

      r = rand_req(OP_START);
      r.host_length = 8'(len);
      queue_req(r);

      b0 = ($urandom_range(0, 9) == 0) ? 8'($urandom) : SOCKS_VER;
      b1 = ($urandom_range(0, 9) == 0) ? 8'($urandom) : METHOD_NO_AUTH;
      queue_rx(b0);
      queue_rx(b1);
      bad = (b0 != SOCKS_VER) || (b1 != METHOD_NO_AUTH) || (len == 0);
      if (bad) begin
         if ($urandom_range(0, 1) == 1) queue_noise();
         return;
      end

      // Long host names are cut short, and the next start drops them.
      if (len > 24) begin
         repeat ($urandom_range(0, 4)) queue_req(rand_req(OP_HOST));
         return;
      end
      if ($urandom_range(0, 19) == 0) begin
         queue_rx(8'($urandom));
         return;
      end
      for (k = 0; k < len; k++)
         queue_req(rand_req(OP_HOST));

      b0 = ($urandom_range(0, 9) == 0) ? 8'($urandom) : SOCKS_VER;
      b1 = ($urandom_range(0, 9) == 0) ? 8'($urandom) : REP_SUCCESS;
      pick = $urandom_range(0, 9);
      if (pick == 0)
         atyp = 8'($urandom);
      else if (pick <= 3)
         atyp = ATYP_IPV4;
      else if (pick <= 6)
         atyp = ATYP_DOMAIN;
      else
         atyp = ATYP_IPV6;
      queue_rx(b0);
      queue_rx(b1);
      queue_rx(8'($urandom));
      queue_rx(atyp);
      if (b0 != SOCKS_VER || b1 != REP_SUCCESS) begin
         if ($urandom_range(0, 1) == 1) queue_noise();
         return;
      end

      if (atyp == ATYP_IPV4) begin
         skip = int'(SKIP_IPV4);
      end else if (atyp == ATYP_IPV6) begin
         skip = int'(SKIP_IPV6);
      end else if (atyp == ATYP_DOMAIN) begin
         b0 = ($urandom_range(0, 9) == 0) ? 8'($urandom_range(0, 255))
                                          : 8'($urandom_range(0, 10));
         queue_rx(b0);
         skip = int'(b0) + int'(SKIP_PORT);
      end else begin
         if ($urandom_range(0, 1) == 1) queue_noise();
         return;
      end

      // A long bound address is only partly skipped before the next start.
      if (skip > 30) begin
         repeat ($urandom_range(0, 5)) queue_rx(8'($urandom));
         return;
      end
      for (k = 0; k < skip; k++)
         queue_rx(8'($urandom));

      // Once connected, anything other than a start is out of sequence.
      if ($urandom_range(0, 4) == 0) queue_noise();
   endtask

   // ---------------------------------------------------------------------
   // Driving, prediction and checking
   // ---------------------------------------------------------------------

   task automatic note_failure();
      fail_count++;
   endtask

   // Prediction and checking share one block. A request accepted at an edge
   // is therefore predicted before any result accepted at that same edge is
   // compared.
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         rsp_stall <= 1'b0;
         socks_model_reset();
      end else begin
         req_taken = req_valid && !req_stall;
         if (req_taken) begin
            predict_socks_step(cur_req);
            if (cur_req.chk == CHK_TYPED) begin
               owed_rsps.insert(owed_rsps.size(),
                                '{KIND_STATUS, 8'h00, cur_req.chk_status, 1'b1});
            end else begin
               foreach (step_rsps[i]) owed_rsps.insert(owed_rsps.size(), step_rsps[i]);
            end
         end

         if (rsp_valid && !rsp_stall) begin
            got_rsp = '{rsp_kind, rsp_tx_byte, rsp_status, rsp_last};
            if (owed_rsps.size() == 0) begin
               if (fail_count < MAX_REPORTS)
                  $display("unexpected result: kind=%0d tx=%02h status=%0d last=%0d",
                           rsp_kind, rsp_tx_byte, rsp_status, rsp_last);
               note_failure();
            end else if (got_rsp != owed_rsps[0]) begin
               if (fail_count < MAX_REPORTS)
                  $display({"mismatch: expected kind=%0d tx=%02h status=%0d last=%0d,",
                            " got kind=%0d tx=%02h status=%0d last=%0d"},
                           owed_rsps[0].kind, owed_rsps[0].tx_byte, owed_rsps[0].status,
                           owed_rsps[0].last, rsp_kind, rsp_tx_byte, rsp_status, rsp_last);
               note_failure();
               void'(owed_rsps.pop_front());
            end else begin
               void'(owed_rsps.pop_front());
            end
         end

         // The payload changes only once the current request has gone in.
         // Valid likewise stays set while the offered request is stalled.
         if (!req_valid || req_taken) begin
            if (req_backlog.size() > 0 && $urandom_range(0, 99) >= send_idle_pct) begin
               cur_req   <= req_backlog.pop_front();
               req_valid <= 1'b1;
            end else begin
               req_valid <= 1'b0;
            end
         end
         rsp_stall <= ($urandom_range(0, 99) < recv_stall_pct);
      end
   end

   // The sender holds off here until it has nothing left to offer and every
   // result it is owed has arrived. The condition is sampled on the falling
   // edge, away from the edge where the driving block updates it.
   task automatic wait_for_drain();
      while (req_backlog.size() != 0 || req_valid || owed_rsps.size() != 0)
         @(negedge clock);
   endtask

   task automatic run_random_phase(input int send_pct, input int recv_pct);
      int goal;
      goal = req_backlog.size() + PHASE_ITEMS;
      while (req_backlog.size() < goal)
         queue_session();
      send_idle_pct  = send_pct;
      recv_stall_pct = recv_pct;
      wait_for_drain();
   endtask

   initial begin
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Walk the directed table at full rate on both sides.
      for (int i = 0; i < NUM_DIRECTED; i++)
         queue_req(directed_tbl[i]);
      wait_for_drain();

      // Random phases: no idling, an idle sender, a stalling receiver, and
      // both together. Each phase drains before the next one starts.
      run_random_phase(0, 0);
      run_random_phase(68, 0);
      run_random_phase(0, 68);
      run_random_phase(28, 28);

      // Let any stray result show up before the verdict.
      send_idle_pct  = 0;
      recv_stall_pct = 0;
      repeat (SETTLE_CYCLES) @(negedge clock);

      if (fail_count == 0 && owed_rsps.size() == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

   // Past this point the unit is taken to be hung.
   initial begin
      #2_000_000;
      $display("*** FAILED ***");
      $finish;
   end

endmodule

FILE: socks5_connect_handshake_unit.f
sv/s5h_pkg.sv
sv/s5h_front.sv
sv/s5h_fifo.sv
sv/s5h_back.sv
sv/socks5_connect_handshake_unit.sv
tb/sv/tb_socks5_connect_handshake_unit.sv
